FILE: rtl/core/svma_pkg.sv
package svma_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int POS_W   = 16;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_RUN    = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic begin_run;
    logic step;
    logic flush;
  } svma_cmd_t;

  typedef struct packed {
    logic merge_done;
  } svma_status_t;

endpackage

FILE: rtl/core/sparse_vector_merge_add_unit.sv
// A load beat leaves busy low, and the next beat may follow at once.
// A run beat holds busy through the merge steps (at most count A + count B), the done check and the flush.
// One merge step per cycle compares the two list heads; each kept result waits in a pending register until the next.
// The final beat (last, with empty_res also set when nothing survives) comes in the same cycle that busy falls.
// Synchronous reset empties both lists and returns to idle; stored entries are not cleared.
// Result beats are shown for one cycle each on strobe, since the receiver cannot stall.
module sparse_vector_merge_add_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic        [1:0]                   action,
  input  logic signed [svma_pkg::VALUE_W-1:0] entry_value,
  input  logic        [svma_pkg::POS_W-1:0]   entry_position,
  output logic                                strobe,
  output logic signed [svma_pkg::VALUE_W-1:0] out_value,
  output logic        [svma_pkg::POS_W-1:0]   out_position,
  output logic                                last,
  output logic                                empty_res
);
  import svma_pkg::*;

  svma_cmd_t    cmd;
  svma_status_t status;

  svma_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action_t'(action)),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  svma_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .entry_value    (entry_value),
    .entry_position (entry_position),
    .status         (status),
    .strobe         (strobe),
    .out_value      (out_value),
    .out_position   (out_position),
    .last           (last),
    .empty_res      (empty_res)
  );

endmodule

FILE: rtl/core/svma_ctrl.sv
module svma_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  svma_pkg::action_t     action,
  input  svma_pkg::svma_status_t status,
  output svma_pkg::svma_cmd_t   cmd,
  output logic                  busy
);
  import svma_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (action)
            ACT_LOAD_A: cmd.load_a = 1'b1;
            ACT_LOAD_B: cmd.load_b = 1'b1;
            ACT_RUN: begin
              cmd.begin_run = 1'b1;
              state_next    = ST_MERGE;
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (status.merge_done) begin
          state_next = ST_FLUSH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/svma_datapath.sv
module svma_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  svma_pkg::svma_cmd_t                 cmd,
  input  logic signed [svma_pkg::VALUE_W-1:0] entry_value,
  input  logic        [svma_pkg::POS_W-1:0]   entry_position,
  output svma_pkg::svma_status_t              status,
  output logic                                strobe,
  output logic signed [svma_pkg::VALUE_W-1:0] out_value,
  output logic        [svma_pkg::POS_W-1:0]   out_position,
  output logic                                last,
  output logic                                empty_res
);
  import svma_pkg::*;

  logic [VALUE_W-1:0] a_values    [DEPTH];
  logic [POS_W-1:0]   a_positions [DEPTH];
  logic [VALUE_W-1:0] b_values    [DEPTH];
  logic [POS_W-1:0]   b_positions [DEPTH];

  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic [CNT_W-1:0] ia;
  logic [CNT_W-1:0] ib;

  logic               pend_valid;
  logic [VALUE_W-1:0] pend_value;
  logic [POS_W-1:0]   pend_position;

  logic               a_avail;
  logic               b_avail;
  logic [VALUE_W-1:0] a_val;
  logic [POS_W-1:0]   a_pos;
  logic [VALUE_W-1:0] b_val;
  logic [POS_W-1:0]   b_pos;
  logic               take_a;
  logic               take_b;
  logic [VALUE_W-1:0] cand_value;
  logic [POS_W-1:0]   cand_position;
  logic               cand_keep;

  always_comb begin
    a_avail = (ia < count_a);
    b_avail = (ib < count_b);
    a_val   = a_values[ia[IDX_W-1:0]];
    a_pos   = a_positions[ia[IDX_W-1:0]];
    b_val   = b_values[ib[IDX_W-1:0]];
    b_pos   = b_positions[ib[IDX_W-1:0]];
    take_a  = a_avail && (!b_avail || (a_pos <= b_pos));
    take_b  = b_avail && (!a_avail || (b_pos <= a_pos));
    if (take_a && take_b) begin
      cand_value    = a_val + b_val;
      cand_position = a_pos;
      cand_keep     = (cand_value != '0);
    end else if (take_a) begin
      cand_value    = a_val;
      cand_position = a_pos;
      cand_keep     = 1'b1;
    end else begin
      cand_value    = b_val;
      cand_position = b_pos;
      cand_keep     = take_b;
    end
    status.merge_done = !a_avail && !b_avail;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a && (count_a < CNT_W'(DEPTH))) begin
      a_values[count_a[IDX_W-1:0]]    <= entry_value;
      a_positions[count_a[IDX_W-1:0]] <= entry_position;
    end
    if (cmd.load_b && (count_b < CNT_W'(DEPTH))) begin
      b_values[count_b[IDX_W-1:0]]    <= entry_value;
      b_positions[count_b[IDX_W-1:0]] <= entry_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a    <= '0;
      count_b    <= '0;
      ia         <= '0;
      ib         <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.load_a && (count_a < CNT_W'(DEPTH))) begin
        count_a <= count_a + 1'b1;
      end
      if (cmd.load_b && (count_b < CNT_W'(DEPTH))) begin
        count_b <= count_b + 1'b1;
      end
      if (cmd.begin_run) begin
        ia         <= '0;
        ib         <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.step) begin
        if (take_a) begin
          ia <= ia + 1'b1;
        end
        if (take_b) begin
          ib <= ib + 1'b1;
        end
        if (cand_keep) begin
          pend_valid <= 1'b1;
          strobe     <= pend_valid;
        end
      end
      if (cmd.flush) begin
        strobe     <= 1'b1;
        pend_valid <= 1'b0;
        count_a    <= '0;
        count_b    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && cand_keep) begin
      pend_value    <= cand_value;
      pend_position <= cand_position;
      out_value     <= pend_value;
      out_position  <= pend_position;
      last          <= 1'b0;
      empty_res     <= 1'b0;
    end
    if (cmd.flush) begin
      out_value     <= pend_valid ? pend_value : '0;
      out_position  <= pend_valid ? pend_position : '0;
      last          <= 1'b1;
      empty_res     <= !pend_valid;
    end
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && empty_res |-> last)
    else $error("empty result without last");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && empty_res |-> (out_value == '0) && (out_position == '0))
    else $error("empty result carries data");

  a_flush_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> strobe && last && (count_a == '0) && (count_b == '0))
    else $error("flush did not emit the final beat or clear the lists");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CNT_W'(DEPTH)) && (count_b <= CNT_W'(DEPTH)))
    else $error("list count beyond depth");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (ia <= count_a) && (ib <= count_b))
    else $error("merge index passed list end");

endmodule
